[rtl/bba_pkg.sv]
// Shared types, codes and helpers for the bitmap block allocator.
// Depends on nothing; every rtl file of the block imports it.
package bba_pkg;

    // Word pointer width: at most 8160 blocks are ever managed, so 255 words.
    localparam int WPTR_W = 8;

    localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;
    localparam logic [12:0] COUNT_MAX = 13'd8191;

    // Register reset values
    localparam logic [12:0] TOTAL_RST = 13'd4096;
    localparam logic [11:0] FIRST_RST = 12'd1;

    // Register select (paddr bit 2)
    localparam logic REG_TOTAL = 1'b0;
    localparam logic REG_FIRST = 1'b1;

    // Operation codes
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_FORMAT = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Status codes
    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_FULL = 2'd1;
    localparam logic [1:0] STS_BAD  = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] block_index;
    } t_req;

    typedef struct packed {
        logic [11:0] allocated_block;
        logic [1:0]  status;
        logic [12:0] used_count;
    } t_rsp;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Commands from the control logic to the map memory
    typedef struct packed {
        logic              rd_en;
        logic [WPTR_W-1:0] rd_word;
        logic              wr_en;
        logic [WPTR_W-1:0] wr_word;
        logic [31:0]       wr_data;
        logic              clr_all;
        logic [WPTR_W-1:0] fmt_word;
        logic [31:0]       fmt_mask;
    } t_map_cmd;

    // Position of the highest clear bit (caller checks the word is not full)
    function automatic logic [4:0] hi_clear(input logic [31:0] bits);
        logic [4:0] pos;
        pos = '0;
        for (int b = 0; b < 32; b++) begin
            if (!bits[b]) begin
                pos = 5'(b);
            end
        end
        return pos;
    endfunction

endpackage

[rtl/bba_map.sv]
// Usage map storage: one synchronous RAM of 32-bit words, registered read.
// Per-word valid flags let format skip a clearing pass; depends on bba_pkg.
module bba_map #(
    parameter int WORDS = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bba_pkg::t_map_cmd i_cmd,
    output logic [31:0]       o_rdata
);
    import bba_pkg::*;

    // Never more than 255 words are addressed
    localparam int MEM_WORDS = (WORDS > 256) ? 256 : WORDS;
    localparam int MA        = $clog2(MEM_WORDS);

    logic [31:0]          r_mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] r_vld;
    logic [WPTR_W-1:0]    r_fmt_word;
    logic [31:0]          r_fmt_mask;
    logic [31:0]          r_q;
    logic                 r_hit;
    logic [31:0]          r_dflt;

    logic [MA-1:0] rd_a;
    logic [MA-1:0] wr_a;

    assign rd_a = i_cmd.rd_word[MA-1:0];
    assign wr_a = i_cmd.wr_word[MA-1:0];

    // RAM array
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_a] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_q <= r_mem[rd_a];
        end
    end

    // Valid flags and the formatted content of the reserved word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_fmt_word <= '0;
            r_fmt_mask <= 32'd1;
        end else if (i_cmd.clr_all) begin
            r_vld      <= '0;
            r_fmt_word <= i_cmd.fmt_word;
            r_fmt_mask <= i_cmd.fmt_mask;
        end else if (i_cmd.wr_en) begin
            r_vld[wr_a] <= 1'b1;
        end
    end

    // Read side: select stored word or its formatted value
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_hit  <= r_vld[rd_a];
            r_dflt <= (i_cmd.rd_word == r_fmt_word) ? r_fmt_mask : '0;
        end
    end

    assign o_rdata = r_hit ? r_q : r_dflt;

endmodule

[rtl/bitmap_block_allocator.sv]
// Bitmap block allocator top level: control, registers and result register.
// Depends on bba_pkg and bba_map.
//
// Usage: a request (op, block_index) enters on i_req_valid/o_req_ready and
// gives exactly one response (allocated_block, status, used_count) on
// o_rsp_valid/i_rsp_ready. total_blocks and first_usable_block sit on the
// APB port at 0x0 and 0x4; write them only while no request is in flight.
// Sequence: free, format and an allocate that finds room in its first word
// read one map word and answer from the execute state; an allocate reads
// each full word it skips in turn, up to one lap of the usable words.
// A request is taken only in the idle state, once the previous one has done
// its single read-modify-write of a map word through the registered RAM read.
// Reset: registers return to 4096 and 1, the map reads as formatted at once
// (per-word valid flags are cleared, no clearing pass), count is zero.
// A new request is taken while the previous response is still waiting;
// if the receiver stalls, the block holds its finished work until the
// response register frees, and accepts nothing more meanwhile.
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  bba_pkg::t_req  i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output bba_pkg::t_rsp  o_rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import bba_pkg::*;

    localparam int WORDS   = MAX_BLOCKS / 32;
    localparam int CAP_INT = (WORDS * 32 > 8160) ? 8160 : WORDS * 32;
    localparam logic [12:0] CAP = 13'(CAP_INT);

    // Registers
    logic [12:0]       r_total;
    logic [11:0]       r_first;
    t_state            r_state, n_state;
    logic [1:0]        r_op, n_op;
    logic [11:0]       r_idx, n_idx;
    logic [WPTR_W-1:0] r_w, n_w;
    logic [WPTR_W-1:0] r_lap, n_lap;
    logic [WPTR_W-1:0] r_scan, n_scan;
    logic [12:0]       r_used, n_used;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_rsp, n_rsp;

    // Effective configuration
    logic [12:0]       t_round, eff_t, eff_f;
    logic [WPTR_W-1:0] words, fw, start_w, lap_len;
    logic [31:0]       rsv_mask;

    // Execute-side signals
    t_map_cmd          map_cmd;
    logic [31:0]       map_rdata;
    logic [31:0]       rd_bits;
    logic              word_full;
    logic [4:0]        hit_bit;
    logic [WPTR_W:0]   w_inc;
    logic [WPTR_W-1:0] nxt_w;
    logic              lap_done;
    logic              out_free;
    logic              idx_bad;
    logic [12:0]       idx_ext;
    logic              req_acc;
    logic              cfg_wr;

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_RST;
            r_first <= FIRST_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_TOTAL: r_total <= pwdata[12:0];
                REG_FIRST: r_first <= pwdata[11:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TOTAL: prdata = {19'd0, r_total};
            REG_FIRST: prdata = {20'd0, r_first};
            default:   prdata = '0;
        endcase
    end

    // Effective size, first usable block and derived word bounds
    always_comb begin
        t_round = {r_total[12:5], 5'd0};
        eff_t   = (t_round < 13'd32) ? 13'd32 : t_round;
        if (eff_t > CAP) begin
            eff_t = CAP;
        end
        eff_f    = ({1'b0, r_first} >= eff_t) ? (eff_t - 13'd1) : {1'b0, r_first};
        words    = eff_t[12:5];
        fw       = eff_f[12:5];
        rsv_mask = (32'd1 << eff_f[4:0]) - 32'd1;
        lap_len  = words - fw;
        start_w  = (r_scan >= fw && r_scan < words) ? r_scan : fw;
    end

    // Word evaluation on the registered read data
    assign rd_bits   = map_rdata | ((r_w == fw) ? rsv_mask : 32'd0);
    assign word_full = (rd_bits == ALL_ONES);
    assign hit_bit   = hi_clear(rd_bits);
    assign w_inc     = {1'b0, r_w} + {{WPTR_W{1'b0}}, 1'b1};
    assign nxt_w     = (w_inc >= {1'b0, words}) ? fw : w_inc[WPTR_W-1:0];
    assign lap_done  = (({1'b0, r_lap} + {{WPTR_W{1'b0}}, 1'b1}) >= {1'b0, lap_len});
    assign idx_ext   = {1'b0, r_idx};
    assign idx_bad   = (idx_ext < eff_f) || (idx_ext >= eff_t);
    assign out_free  = !r_out_valid || i_rsp_ready;

    assign o_req_ready = (r_state == S_IDLE);
    assign req_acc     = i_req_valid && o_req_ready;

    // Sequencer: next state, map commands and response
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_idx       = r_idx;
        n_w         = r_w;
        n_lap       = r_lap;
        n_scan      = r_scan;
        n_used      = r_used;
        n_out_valid = r_out_valid && !i_rsp_ready;
        n_rsp       = r_rsp;
        map_cmd     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_op  = i_req.op;
                    n_idx = i_req.block_index;
                    n_lap = '0;
                    map_cmd.rd_en = 1'b1;
                    if (i_req.op == OP_FREE) begin
                        n_w = {1'b0, i_req.block_index[11:5]};
                    end else begin
                        n_w = start_w;
                    end
                    map_cmd.rd_word = n_w;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_ALLOC: begin
                        if (!word_full) begin
                            if (out_free) begin
                                map_cmd.wr_en   = 1'b1;
                                map_cmd.wr_word = r_w;
                                map_cmd.wr_data = map_rdata | (32'd1 << hit_bit);
                                n_scan = r_w;
                                n_used = (r_used < COUNT_MAX) ? r_used + 13'd1 : r_used;
                                n_rsp.allocated_block = {r_w[6:0], hit_bit};
                                n_rsp.status          = STS_OK;
                                n_rsp.used_count      = n_used;
                                n_out_valid = 1'b1;
                                n_state     = S_IDLE;
                            end
                        end else if (lap_done) begin
                            if (out_free) begin
                                n_rsp.allocated_block = '0;
                                n_rsp.status          = STS_FULL;
                                n_rsp.used_count      = r_used;
                                n_out_valid = 1'b1;
                                n_state     = S_IDLE;
                            end
                        end else begin
                            // word full: move on to the next one
                            map_cmd.rd_en   = 1'b1;
                            map_cmd.rd_word = nxt_w;
                            n_w   = nxt_w;
                            n_lap = r_lap + {{(WPTR_W-1){1'b0}}, 1'b1};
                        end
                    end
                    OP_FREE: begin
                        if (out_free) begin
                            if (!idx_bad && map_rdata[r_idx[4:0]]) begin
                                map_cmd.wr_en   = 1'b1;
                                map_cmd.wr_word = r_w;
                                map_cmd.wr_data = map_rdata & ~(32'd1 << r_idx[4:0]);
                                n_used = (r_used != '0) ? r_used - 13'd1 : r_used;
                            end
                            n_rsp.allocated_block = '0;
                            n_rsp.status          = idx_bad ? STS_BAD : STS_OK;
                            n_rsp.used_count      = n_used;
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    OP_FORMAT: begin
                        if (out_free) begin
                            map_cmd.clr_all  = 1'b1;
                            map_cmd.fmt_word = fw;
                            map_cmd.fmt_mask = rsv_mask;
                            n_scan = fw;
                            n_used = '0;
                            n_rsp.allocated_block = '0;
                            n_rsp.status          = STS_OK;
                            n_rsp.used_count      = '0;
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    default: begin
                        // unused op: answer only
                        if (out_free) begin
                            n_rsp.allocated_block = '0;
                            n_rsp.status          = STS_OK;
                            n_rsp.used_count      = r_used;
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan      <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_lap       <= '0;
        end else begin
            r_state     <= n_state;
            r_scan      <= n_scan;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            r_lap       <= n_lap;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_idx <= n_idx;
        r_w   <= n_w;
        r_rsp <= n_rsp;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;

    bba_map #(
        .WORDS (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (map_cmd),
        .o_rdata (map_rdata)
    );

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for bitmap_block_allocator: directed and random requests
// with random idling, checked against a behavioral model of the block's map.
// Depends on bba_pkg and the bitmap_block_allocator RTL.
module tb_top;
    import bba_pkg::*;

    // Behavioral copy of the allocator plus the queue of results still awaited
    class alloc_scoreboard;
        localparam int unsigned MAP_BLOCKS = 4096;

        logic [31:0] usage_map [128];
        int unsigned scan_word;
        int unsigned used_blocks;
        int unsigned total_reg;
        int unsigned first_reg;
        t_rsp        awaited_rsps [$];
        int unsigned errors;
        int unsigned n_checked;
        int unsigned n_granted;
        int unsigned n_full;
        int unsigned n_rejected;
        int unsigned n_formats;

        function void reset_state();
            total_reg = 32'(TOTAL_RST);
            first_reg = 32'(FIRST_RST);
            format_map();
        endfunction

        // Size rounded to whole words and clamped to what the map holds
        function int unsigned eff_size();
            int unsigned t;
            t = total_reg & ~32'd31;
            if (t < 32) t = 32;
            if (t > MAP_BLOCKS) t = MAP_BLOCKS;
            return t;
        endfunction

        function int unsigned eff_first();
            int unsigned t;
            t = eff_size();
            return (first_reg >= t) ? t - 1 : first_reg;
        endfunction

        // Clear the map; only the word holding the first usable block gets reserved bits
        function void format_map();
            int unsigned f;
            f = eff_first();
            foreach (usage_map[i]) usage_map[i] = '0;
            used_blocks = 0;
            scan_word = f >> 5;
            usage_map[f >> 5] = (32'd1 << (f & 31)) - 32'd1;
        endfunction

        function void write_reg(logic sel, logic [31:0] value);
            if (sel == REG_TOTAL) total_reg = value & 32'h1fff;
            else first_reg = value & 32'h0fff;
        endfunction

        // Apply one accepted request and queue the response it must produce
        function t_rsp note_request(t_req r);
            t_rsp        exp;
            int unsigned t, f, words, fw, w, b, i;
            logic [31:0] bits;
            t = eff_size();
            f = eff_first();
            words = t >> 5;
            fw = f >> 5;
            exp = '0;
            case (r.op)
                OP_ALLOC: begin
                    // next-fit: resume at the saved word unless it is outside the usable range
                    w = (scan_word >= fw && scan_word < words) ? scan_word : fw;
                    exp.status = STS_FULL;
                    for (i = 0; i < words - fw; i++) begin
                        bits = usage_map[w];
                        if (w == fw) bits |= (32'd1 << (f & 31)) - 32'd1;
                        if (bits != ALL_ONES) begin
                            b = 31;
                            while (bits[b]) b--;
                            usage_map[w][b] = 1'b1;
                            scan_word = w;
                            if (used_blocks < COUNT_MAX) used_blocks++;
                            exp.allocated_block = 12'((w << 5) | b);
                            exp.status = STS_OK;
                            break;
                        end
                        w = (w + 1 >= words) ? fw : w + 1;
                    end
                    if (exp.status == STS_OK) n_granted++;
                    else n_full++;
                end
                OP_FREE: begin
                    if (r.block_index < f || r.block_index >= t) begin
                        exp.status = STS_BAD;
                        n_rejected++;
                    end else if (usage_map[r.block_index >> 5][r.block_index & 31]) begin
                        usage_map[r.block_index >> 5][r.block_index & 31] = 1'b0;
                        if (used_blocks > 0) used_blocks--;
                    end
                end
                OP_FORMAT: begin
                    format_map();
                    n_formats++;
                end
                default: ;
            endcase
            exp.used_count = 13'(used_blocks);
            awaited_rsps.push_back(exp);
            return exp;
        endfunction

        function void check_response(t_rsp got);
            t_rsp exp;
            n_checked++;
            if (awaited_rsps.size() == 0) begin
                $display("%0t: response with none awaited: block %0d status %0d count %0d",
                         $time, got.allocated_block, got.status, got.used_count);
                errors++;
                return;
            end
            exp = awaited_rsps.pop_front();
            if (got.allocated_block !== exp.allocated_block) begin
                $display("%0t: allocated_block expected %0d got %0d",
                         $time, exp.allocated_block, got.allocated_block);
                errors++;
            end
            if (got.status !== exp.status) begin
                $display("%0t: status expected %0d got %0d", $time, exp.status, got.status);
                errors++;
            end
            if (got.used_count !== exp.used_count) begin
                $display("%0t: used_count expected %0d got %0d",
                         $time, exp.used_count, got.used_count);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_req_valid = 1'b0;
    t_req        i_req       = '0;
    logic        o_req_ready;
    logic        o_rsp_valid;
    logic        i_rsp_ready = 1'b0;
    t_rsp        o_rsp;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    alloc_scoreboard sb;
    bit              calm = 1'b0;
    int unsigned     stall_left = 0;
    int unsigned     alloc_pct = 50;
    int unsigned     n_settings = 0;
    int unsigned     n_sent = 0;
    logic [11:0]     last_block = '0;
    int unsigned     live_blocks [$];
    int unsigned     phase_total [9] = '{4096, 32, 64, 96, 160, 4096, 8191, 0, 0};
    int unsigned     phase_first [9] = '{1, 1, 17, 95, 33, 4000, 4095, 0, 0};

    bitmap_block_allocator dut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("tb_top failed");
        $finish;
    end

    // Response side: random short stalls, now and then a long one
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_rsp_ready <= 1'b0;
        end else if (!calm && $urandom_range(99) < 8) begin
            stall_left <= ($urandom_range(49) == 0) ? $urandom_range(40) : 0;
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready) sb.check_response(o_rsp);
    end

    // Present one request, wait for its acceptance, then predict its response
    task automatic send_req(input logic [1:0] op, input logic [11:0] idx);
        t_req r;
        t_rsp exp;
        r.op = op;
        r.block_index = idx;
        if (!calm && $urandom_range(99) < 8) begin
            i_req_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 20);
        end
        i_req_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (!o_req_ready);
        exp = sb.note_request(r);
        n_sent++;
        if (op == OP_FORMAT) live_blocks.delete();
        if (op == OP_ALLOC && exp.status == STS_OK) begin
            last_block = exp.allocated_block;
            live_blocks.push_back(32'(exp.allocated_block));
        end
    endtask

    // Hold off new requests until every awaited response is back
    task automatic drain();
        i_req_valid <= 1'b0;
        do @(posedge i_clk); while (sb.awaited_rsps.size() != 0);
    endtask

    // Setup and access cycle; psel stays high so writes can run back to back
    task automatic write_reg(input logic sel, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.write_reg(sel, value);
    endtask

    task automatic configure(input int unsigned total, input int unsigned first);
        drain();
        repeat (2) @(posedge i_clk);
        write_reg(REG_TOTAL, total);
        write_reg(REG_FIRST, first);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        n_settings++;
    endtask

    // Indices right at the edges of the usable range
    function automatic logic [11:0] boundary_index();
        int unsigned f, t;
        f = sb.eff_first();
        t = sb.eff_size();
        case ($urandom_range(5))
            0: return 12'(f - 1);
            1: return 12'(f);
            2: return 12'(t - 1);
            3: return 12'(t);
            4: return 12'd0;
            default: return 12'hfff;
        endcase
    endfunction

    task automatic random_item();
        int unsigned roll, pos;
        logic [11:0] idx;
        roll = $urandom_range(99);
        idx = 12'($urandom);
        if (roll >= 97) begin
            send_req(OP_FORMAT, idx);
        end else if (roll >= 94) begin
            send_req(OP_NONE, idx);
        end else if (roll >= 90) begin
            send_req(OP_FREE, boundary_index());
        end else if (roll >= 84 || (roll >= alloc_pct && live_blocks.size() == 0)) begin
            send_req(OP_FREE, idx);
        end else if (roll < alloc_pct) begin
            send_req(OP_ALLOC, idx);
        end else begin
            // free a block that is known to be held
            pos = $urandom_range(live_blocks.size() - 1);
            idx = 12'(live_blocks[pos]);
            live_blocks.delete(pos);
            send_req(OP_FREE, idx);
        end
    endtask

    initial begin
        int p, k;
        sb = new();
        sb.reset_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: grant, free, double free, reserved and top index, unused op, format
        send_req(OP_ALLOC, 12'd0);
        send_req(OP_ALLOC, 12'hfff);
        send_req(OP_FREE, last_block);
        send_req(OP_FREE, last_block);
        send_req(OP_FREE, 12'd0);
        send_req(OP_FREE, 12'hfff);
        send_req(OP_NONE, 12'hfff);
        send_req(OP_FORMAT, 12'hfff);
        send_req(OP_ALLOC, 12'h555);

        // Two usable blocks: fill, then full map, a free, then a free past the end
        configure(32, 30);
        send_req(OP_FORMAT, 12'd0);
        send_req(OP_ALLOC, 12'd0);
        send_req(OP_ALLOC, 12'd0);
        send_req(OP_ALLOC, 12'd0);
        send_req(OP_FREE, 12'd30);
        send_req(OP_FREE, 12'd32);

        // Reserved bits freed after lowering the first block: count stays at zero;
        // then a shrunk map leaves the scan pointer outside the usable words
        configure(64, 40);
        send_req(OP_FORMAT, 12'd0);
        configure(64, 1);
        send_req(OP_FREE, 12'd35);
        configure(0, 1);
        send_req(OP_ALLOC, 12'd0);

        // Oversized total and a first block at the very top: one usable block
        configure(8191, 4095);
        send_req(OP_FORMAT, 12'd0);
        send_req(OP_ALLOC, 12'd0);
        send_req(OP_ALLOC, 12'd0);
        send_req(OP_FREE, 12'hfff);

        // No reserved blocks at all
        configure(0, 0);
        send_req(OP_FORMAT, 12'd0);
        send_req(OP_ALLOC, 12'd0);

        // Random phases, one register setting each; the first runs without idling
        for (p = 0; p < 9; p++) begin
            if (p == 7) begin
                phase_total[p] = $urandom_range(32, 512);
                phase_first[p] = $urandom_range(0, 600);
            end
            configure(phase_total[p], phase_first[p]);
            calm = (p == 0);
            alloc_pct = (p == 0 || p == 6) ? 50 : 65;
            if ($urandom_range(4) != 0) send_req(OP_FORMAT, 12'($urandom));
            for (k = 0; k < 117; k++) begin
                if (p == 3 && k == 60) drain();
                random_item();
            end
        end
        calm = 1'b0;

        drain();
        repeat (20) @(posedge i_clk);
        $display("Run: %0d requests over %0d register settings, %0d responses checked.",
                 n_sent, n_settings, sb.n_checked);
        $display("Covered %0d grants, %0d full-map answers, %0d rejected frees, %0d formats.",
                 sb.n_granted, sb.n_full, sb.n_rejected, sb.n_formats);
        if (sb.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/bba_pkg.sv
rtl/bba_map.sv
rtl/bitmap_block_allocator.sv
tb/sv/tb_top.sv
